/* sv/wrhc_pkg.sv */
// ----------------------------------------------------------------------------
// wrhc_pkg
// shared types and constants of the wildcard rule hash cache
// ----------------------------------------------------------------------------
package wrhc_pkg;

  localparam int KEY_W   = 64;
  localparam int EVENT_W = 16;
  localparam logic [KEY_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;

  typedef enum logic [2:0] {
    ACT_BEGIN   = 3'd0,
    ACT_STAGE   = 3'd1,
    ACT_PREPARE = 3'd2,
    ACT_PUBLISH = 3'd3,
    ACT_ABORT   = 3'd4,
    ACT_RESET   = 3'd5,
    ACT_LOOKUP  = 3'd6,
    ACT_RSVD    = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_PERM     = 3'd2,
    ST_ALREADY  = 3'd3,
    ST_TOO_MANY = 3'd4,
    ST_EXISTS   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_CUR_GEN    = 2'd0,
    CFG_DOMAIN_ANY = 2'd1,
    CFG_SEL_ANY    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic       load;
    logic       hash_start;
    logic       mix_step;
    logic       mod_step;
    logic       probe_start;
    logic       probe_adv;
    logic       rd;
    logic       ins;
    logic       clr_init;
    logic       clr_step;
    logic       beg;
    logic       pub;
    logic       fin;
    logic       bank;
    logic [2:0] variant;
    status_t    st;
    logic       found;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    gen_zero;
    logic    gen_eq_stg;
    logic    act_gen_match;
    logic    cnt_full;
    logic    ans_bad;
    logic    mix_last;
    logic    mod_last;
    logic    clr_last;
    logic    used_q;
    logic    key_hit;
    logic    probe_full;
  } sts_t;

  // wildcard variant order: bit0 subject, bit1 object, bit2 selector
  function automatic logic [2:0] probe_variant(input logic [2:0] idx);
    logic [2:0] w;
    case (idx)
      3'd3:    w = 3'd4;
      3'd4:    w = 3'd3;
      default: w = idx;
    endcase
    return w;
  endfunction

endpackage

/* sv/wildcard_rule_hash_cache.sv */
// ----------------------------------------------------------------------------
// wildcard_rule_hash_cache
// double-banked rule cache with linear-probing insert and wildcard lookup
// ----------------------------------------------------------------------------
// prepare, publish, abort, reset, rejected words: decided in the decode state, result strobe registered
// stage: hash, remainder, then a read and compare per slot probed; lookup: up to 8 keys, each hashed and probed
// begin: clears the staging bank, one slot cleared per cycle in the used-bit memory
// one word at a time; busy stays high until the result strobe, receiver cannot stall
// after reset busy is high while the used bits of both banks are cleared
module wildcard_rule_hash_cache #(
  parameter int MAX_RULES      = 4096,
  parameter int SLOTS_PER_BANK = 8192,
  parameter int EVENT_ID_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_action,
  input  logic [wrhc_pkg::EVENT_W-1:0] in_event_id,
  input  logic [wrhc_pkg::KEY_W-1:0]   in_subject_domain,
  input  logic [wrhc_pkg::KEY_W-1:0]   in_object_domain,
  input  logic [wrhc_pkg::KEY_W-1:0]   in_selector,
  input  logic [1:0]                   in_rule_answer,
  input  logic [wrhc_pkg::KEY_W-1:0]   in_generation,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [wrhc_pkg::KEY_W-1:0]   cfg_wdata,
  output logic                         out_valid,
  output logic [2:0]                   out_status,
  output logic                         out_found,
  output logic                         out_decision
);
  import wrhc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wrhc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  wrhc_dp #(
    .MAX_RULES      (MAX_RULES),
    .SLOTS_PER_BANK (SLOTS_PER_BANK),
    .EVENT_ID_BITS  (EVENT_ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_action),
    .in_event_id       (in_event_id),
    .in_subject_domain (in_subject_domain),
    .in_object_domain  (in_object_domain),
    .in_selector       (in_selector),
    .in_rule_answer    (in_rule_answer),
    .in_generation     (in_generation),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_decision      (out_decision)
  );

endmodule

/* sv/wrhc_ctrl.sv */
// ----------------------------------------------------------------------------
// wrhc_ctrl
// sequencer: action decode, bank flags, hash/probe/clear stepping
// ----------------------------------------------------------------------------
module wrhc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  wrhc_pkg::sts_t sts,
  output wrhc_pkg::cmd_t cmd
);
  import wrhc_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_MIX    = 8'b0000_1000,
    S_MOD    = 8'b0001_0000,
    S_RD     = 8'b0010_0000,
    S_CMP    = 8'b0100_0000,
    S_BCLR   = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic       act_valid_r, act_valid_nxt;
  logic       stg_valid_r, stg_valid_nxt;
  logic       prep_valid_r, prep_valid_nxt;
  logic       act_bank_r, act_bank_nxt;
  logic [2:0] var_idx_r, var_idx_nxt;
  logic       is_stage;

  assign busy     = (state_r != S_IDLE);
  assign is_stage = (sts.action == ACT_STAGE);

  always_comb begin
    state_nxt      = state_r;
    act_valid_nxt  = act_valid_r;
    stg_valid_nxt  = stg_valid_r;
    prep_valid_nxt = prep_valid_r;
    act_bank_nxt   = act_bank_r;
    var_idx_nxt    = var_idx_r;
    cmd            = '0;
    cmd.st         = ST_OK;
    cmd.bank       = is_stage ? ~act_bank_r : act_bank_r;
    cmd.variant    = probe_variant(var_idx_r);
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        case (sts.action)
          ACT_BEGIN: begin
            if (sts.gen_zero) begin
              cmd.fin = 1'b1;
              cmd.st  = ST_INVALID;
            end else if (stg_valid_r || prep_valid_r) begin
              cmd.fin = 1'b1;
              cmd.st  = ST_ALREADY;
            end else begin
              cmd.beg       = 1'b1;
              cmd.clr_init  = 1'b1;
              cmd.bank      = ~act_bank_r;
              stg_valid_nxt = 1'b1;
              state_nxt     = S_BCLR;
            end
          end
          ACT_STAGE: begin
            if (!stg_valid_r) begin
              cmd.fin = 1'b1;
              cmd.st  = ST_PERM;
            end else if (sts.cnt_full) begin
              cmd.fin = 1'b1;
              cmd.st  = ST_TOO_MANY;
            end else if (sts.ans_bad) begin
              cmd.fin = 1'b1;
              cmd.st  = ST_INVALID;
            end else begin
              cmd.hash_start = 1'b1;
              cmd.variant    = 3'd0;
              var_idx_nxt    = 3'd0;
              state_nxt      = S_MIX;
            end
          end
          ACT_PREPARE: begin
            cmd.fin = 1'b1;
            if (!stg_valid_r || !sts.gen_eq_stg || prep_valid_r) begin
              cmd.st = ST_PERM;
            end else begin
              stg_valid_nxt  = 1'b0;
              prep_valid_nxt = 1'b1;
            end
          end
          ACT_PUBLISH: begin
            cmd.fin = 1'b1;
            if (!prep_valid_r || !sts.gen_eq_stg) begin
              cmd.st = ST_PERM;
            end else begin
              cmd.pub        = 1'b1;
              act_bank_nxt   = ~act_bank_r;
              act_valid_nxt  = 1'b1;
              prep_valid_nxt = 1'b0;
            end
          end
          ACT_ABORT: begin
            cmd.fin        = 1'b1;
            stg_valid_nxt  = 1'b0;
            prep_valid_nxt = 1'b0;
          end
          ACT_RESET: begin
            cmd.fin        = 1'b1;
            stg_valid_nxt  = 1'b0;
            prep_valid_nxt = 1'b0;
            act_valid_nxt  = 1'b0;
          end
          ACT_LOOKUP: begin
            if (act_valid_r && sts.act_gen_match) begin
              cmd.hash_start = 1'b1;
              cmd.variant    = 3'd0;
              var_idx_nxt    = 3'd0;
              state_nxt      = S_MIX;
            end else begin
              cmd.fin = 1'b1;
            end
          end
          default: begin
            cmd.fin = 1'b1;
            cmd.st  = ST_INVALID;
          end
        endcase
      end
      S_MIX: begin
        cmd.mix_step = 1'b1;
        if (sts.mix_last) state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          cmd.probe_start = 1'b1;
          state_nxt       = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.used_q && sts.key_hit) begin
          cmd.fin   = 1'b1;
          cmd.st    = is_stage ? ST_EXISTS : ST_OK;
          cmd.found = !is_stage;
          state_nxt = S_IDLE;
        end else if (!sts.used_q && is_stage) begin
          cmd.ins   = 1'b1;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.used_q && !sts.probe_full) begin
          cmd.probe_adv = 1'b1;
          state_nxt     = S_RD;
        end else if (is_stage) begin
          cmd.fin   = 1'b1;
          cmd.st    = ST_TOO_MANY;
          state_nxt = S_IDLE;
        end else if (var_idx_r == 3'd7) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          var_idx_nxt    = var_idx_r + 3'd1;
          cmd.hash_start = 1'b1;
          cmd.variant    = probe_variant(var_idx_r + 3'd1);
          state_nxt      = S_MIX;
        end
      end
      S_BCLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      act_valid_r  <= 1'b0;
      stg_valid_r  <= 1'b0;
      prep_valid_r <= 1'b0;
      act_bank_r   <= 1'b0;
      var_idx_r    <= 3'd0;
    end else begin
      state_r      <= state_nxt;
      act_valid_r  <= act_valid_nxt;
      stg_valid_r  <= stg_valid_nxt;
      prep_valid_r <= prep_valid_nxt;
      act_bank_r   <= act_bank_nxt;
      var_idx_r    <= var_idx_nxt;
    end
  end

endmodule

/* sv/wrhc_dp.sv */
// ----------------------------------------------------------------------------
// wrhc_dp
// datapath: input word, config, hash/remainder unit, slot memories, result
// ----------------------------------------------------------------------------
module wrhc_dp #(
  parameter int MAX_RULES      = 4096,
  parameter int SLOTS_PER_BANK = 8192,
  parameter int EVENT_ID_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wrhc_pkg::cmd_t                 cmd,
  output wrhc_pkg::sts_t                 sts,
  input  logic [2:0]                     in_action,
  input  logic [wrhc_pkg::EVENT_W-1:0]   in_event_id,
  input  logic [wrhc_pkg::KEY_W-1:0]     in_subject_domain,
  input  logic [wrhc_pkg::KEY_W-1:0]     in_object_domain,
  input  logic [wrhc_pkg::KEY_W-1:0]     in_selector,
  input  logic [1:0]                     in_rule_answer,
  input  logic [wrhc_pkg::KEY_W-1:0]     in_generation,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_idx,
  input  logic [wrhc_pkg::KEY_W-1:0]     cfg_wdata,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic                           out_found,
  output logic                           out_decision
);
  import wrhc_pkg::*;

  localparam int SLW   = $clog2(SLOTS_PER_BANK);
  localparam int RW    = SLW + 1;
  localparam int AW    = $clog2(2 * SLOTS_PER_BANK);
  localparam int DEPTH = 2 * SLOTS_PER_BANK;
  localparam int CW    = $clog2(MAX_RULES + 1);
  localparam int DW    = EVENT_W + 3 * KEY_W + 1;
  localparam logic [EVENT_W-1:0] EV_MASK = (EVENT_ID_BITS >= EVENT_W) ? {EVENT_W{1'b1}} :
    EVENT_W'((64'd1 << EVENT_ID_BITS) - 64'd1);
  localparam logic [31:0] SPB32 = 32'(SLOTS_PER_BANK);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(SLOTS_PER_BANK));

  // input word and config
  action_t            act_r;
  logic [EVENT_W-1:0] ev_r;
  logic [KEY_W-1:0]   subj_r, obj_r, sel_r, gen_r;
  logic [1:0]         ans_r;
  logic [KEY_W-1:0]   cur_gen_r, dom_any_r, sel_any_r;
  logic [KEY_W-1:0]   stg_gen_r, act_gen_r;
  logic [CW-1:0]      cnt_r;

  // hash and probe
  logic [KEY_W-1:0]   ks_r, ko_r, kp_r, v_r, mix_part;
  logic [1:0]         mix_cnt_r;
  logic [2:0]         mod_cnt_r;
  logic [RW-1:0]      rem_r;
  logic [SLW-1:0]     pn_r;
  logic [AW-1:0]      addr;

  // remainder unit: 16-bit digits, reciprocal estimate then one correction
  logic [15:0]        mod_dig;
  logic [31:0]        mod_x, mod_q_r, mod_r;
  logic [63:0]        mod_prod, mod_qm;

  // memories
  logic [DW-1:0]      data_mem [DEPTH];
  logic               used_mem [DEPTH];
  logic [DW-1:0]      dq_r;
  logic               uq_r;
  logic [AW-1:0]      clr_addr_r, clr_end_r;

  logic               out_valid_r, out_found_r, out_dec_r;
  logic [2:0]         out_status_r;

  function automatic logic [KEY_W-1:0] mix(input logic [KEY_W-1:0] v,
                                           input logic [KEY_W-1:0] p);
    return v ^ (p + GOLDEN + (v << 6) + (v >> 2));
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      ev_r   <= in_event_id & EV_MASK;
      subj_r <= in_subject_domain;
      obj_r  <= in_object_domain;
      sel_r  <= in_selector;
      ans_r  <= in_rule_answer;
      gen_r  <= in_generation;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_gen_r <= '0;
      dom_any_r <= '1;
      sel_any_r <= '1;
      stg_gen_r <= '0;
      act_gen_r <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CUR_GEN:    cur_gen_r <= cfg_wdata;
          CFG_DOMAIN_ANY: dom_any_r <= cfg_wdata;
          CFG_SEL_ANY:    sel_any_r <= cfg_wdata;
          default:        ;
        endcase
      end
      if (cmd.beg) begin
        stg_gen_r <= gen_r;
        cnt_r     <= '0;
      end else if (cmd.ins) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.pub) act_gen_r <= stg_gen_r;
    end
  end

  always_comb begin
    case (mix_cnt_r)
      2'd0:    mix_part = ks_r;
      2'd1:    mix_part = ko_r;
      default: mix_part = kp_r;
    endcase
  end

  always_comb begin
    case (mod_cnt_r[2:1])
      2'd0:    mod_dig = v_r[63:48];
      2'd1:    mod_dig = v_r[47:32];
      2'd2:    mod_dig = v_r[31:16];
      default: mod_dig = v_r[15:0];
    endcase
  end

  assign mod_x    = {16'(rem_r), mod_dig};
  assign mod_prod = 64'(mod_x) * 64'(RECIP);
  assign mod_qm   = 64'(mod_q_r) * 64'(SLOTS_PER_BANK);
  assign mod_r    = mod_x - mod_qm[31:0];

  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      ks_r      <= cmd.variant[0] ? dom_any_r : subj_r;
      ko_r      <= cmd.variant[1] ? dom_any_r : obj_r;
      kp_r      <= cmd.variant[2] ? sel_any_r : sel_r;
      v_r       <= KEY_W'(ev_r);
      mix_cnt_r <= 2'd0;
      mod_cnt_r <= 3'd0;
      rem_r     <= '0;
    end
    if (cmd.mix_step) begin
      v_r       <= mix(v_r, mix_part);
      mix_cnt_r <= mix_cnt_r + 2'd1;
    end
    if (cmd.mod_step) begin
      mod_cnt_r <= mod_cnt_r + 3'd1;
      if (!mod_cnt_r[0]) begin
        mod_q_r <= mod_prod[63:32];
      end else begin
        rem_r <= (mod_r >= SPB32) ? RW'(mod_r - SPB32) : RW'(mod_r);
      end
    end
    if (cmd.probe_start) pn_r <= '0;
    if (cmd.probe_adv) begin
      pn_r  <= pn_r + SLW'(1);
      rem_r <= (rem_r == RW'(SLOTS_PER_BANK - 1)) ? '0 : rem_r + RW'(1);
    end
  end

  assign addr = cmd.bank ? AW'(rem_r[SLW-1:0]) + AW'(SLOTS_PER_BANK)
                         : AW'(rem_r[SLW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.ins) data_mem[addr] <= {ev_r, ks_r, ko_r, kp_r, ans_r[0]};
    if (cmd.rd)  dq_r <= data_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step)  used_mem[clr_addr_r] <= 1'b0;
    else if (cmd.ins)  used_mem[addr] <= 1'b1;
    if (cmd.rd)        uq_r <= used_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_end_r  <= AW'(DEPTH - 1);
    end else if (cmd.clr_init) begin
      clr_addr_r <= cmd.bank ? AW'(SLOTS_PER_BANK) : '0;
      clr_end_r  <= cmd.bank ? AW'(DEPTH - 1) : AW'(SLOTS_PER_BANK - 1);
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
    if (cmd.fin) begin
      out_status_r <= cmd.st;
      out_found_r  <= cmd.found;
      out_dec_r    <= cmd.found & dq_r[0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_decision = out_dec_r;

  always_comb begin
    sts.action        = act_r;
    sts.gen_zero      = (gen_r == '0);
    sts.gen_eq_stg    = (gen_r == stg_gen_r);
    sts.act_gen_match = (act_gen_r == cur_gen_r);
    sts.cnt_full      = (cnt_r >= CW'(MAX_RULES));
    sts.ans_bad       = ans_r[1];
    sts.mix_last      = (mix_cnt_r == 2'd2);
    sts.mod_last      = (mod_cnt_r == 3'd7);
    sts.clr_last      = (clr_addr_r == clr_end_r);
    sts.used_q        = uq_r;
    sts.key_hit       = (dq_r[DW-1:1] == {ev_r, ks_r, ko_r, kp_r});
    sts.probe_full    = (pn_r == SLW'(SLOTS_PER_BANK - 1));
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives rule generations, wildcard lookups and noise into the rule cache and
// checks every result word against a cycle-free prediction of the cache
// ----------------------------------------------------------------------------
module testbench;
  import wrhc_pkg::*;

  localparam int SLOTS = 8192;
  localparam int LIMIT = 4096;
  localparam int STALL_LIMIT = 80000;

  typedef struct {
    action_t     action;
    logic [15:0] ev;
    logic [63:0] subj;
    logic [63:0] obj;
    logic [63:0] sel;
    logic [1:0]  ans;
    logic [63:0] gen;
  } word_t;

  typedef struct {
    status_t st;
    logic    found;
    logic    dec;
  } verdict_t;

  class rule_scoreboard;
    logic [63:0] cur_gen, dom_any, sel_any;
    logic [15:0] s_ev[2*SLOTS];
    logic [63:0] s_sub[2*SLOTS];
    logic [63:0] s_obj[2*SLOTS];
    logic [63:0] s_sel[2*SLOTS];
    bit          s_dec[2*SLOTS];
    bit          s_used[2*SLOTS];
    bit          act_bank, act_valid, stg_valid, prep_valid;
    logic [63:0] stg_gen, act_gen;
    int          count;
    verdict_t    pending[$];
    int          errors;

    function new();
      cur_gen = '0;
      dom_any = '1;
      sel_any = '1;
      foreach (s_used[i]) s_used[i] = 0;
      act_bank = 0; act_valid = 0; stg_valid = 0; prep_valid = 0;
      stg_gen = '0; act_gen = '0; count = 0; errors = 0;
    endfunction

    function void set_cfg(cfg_idx_t idx, logic [63:0] val);
      case (idx)
        CFG_CUR_GEN:    cur_gen = val;
        CFG_DOMAIN_ANY: dom_any = val;
        default:        sel_any = val;
      endcase
    endfunction

    function logic [63:0] mix(logic [63:0] v, logic [63:0] p);
      return v ^ (p + GOLDEN + (v << 6) + (v >> 2));
    endfunction

    // 0 free slot, 1 key hit, 2 bank full
    function int probe(bit bank, logic [15:0] ev, logic [63:0] s, logic [63:0] o,
                       logic [63:0] p, output int at);
      logic [63:0] v;
      int slot, idx;
      v = {48'd0, ev};
      v = mix(v, s);
      v = mix(v, o);
      v = mix(v, p);
      slot = int'(v[12:0]);
      at = 0;
      for (int n = 0; n < SLOTS; n++) begin
        idx = int'(bank) * SLOTS + slot;
        if (!s_used[idx]) begin
          at = idx;
          return 0;
        end
        if (s_ev[idx] == ev && s_sub[idx] == s && s_obj[idx] == o && s_sel[idx] == p) begin
          at = idx;
          return 1;
        end
        slot = (slot + 1) % SLOTS;
      end
      return 2;
    endfunction

    function void note_input(word_t w);
      verdict_t r;
      bit stg_bank;
      int at, k;
      logic [2:0] var_w;
      r.st = ST_OK; r.found = 0; r.dec = 0;
      stg_bank = ~act_bank;
      case (w.action)
        ACT_BEGIN: begin
          if (w.gen == 0) r.st = ST_INVALID;
          else if (stg_valid || prep_valid) r.st = ST_ALREADY;
          else begin
            for (int i = 0; i < SLOTS; i++) s_used[int'(stg_bank) * SLOTS + i] = 0;
            stg_valid = 1; stg_gen = w.gen; count = 0;
          end
        end
        ACT_STAGE: begin
          if (!stg_valid) r.st = ST_PERM;
          else if (count >= LIMIT) r.st = ST_TOO_MANY;
          else if (w.ans > 1) r.st = ST_INVALID;
          else begin
            k = probe(stg_bank, w.ev, w.subj, w.obj, w.sel, at);
            if (k == 1) r.st = ST_EXISTS;
            else if (k == 2) r.st = ST_TOO_MANY;
            else begin
              s_ev[at] = w.ev; s_sub[at] = w.subj; s_obj[at] = w.obj;
              s_sel[at] = w.sel; s_dec[at] = w.ans[0]; s_used[at] = 1;
              count++;
            end
          end
        end
        ACT_PREPARE: begin
          if (!stg_valid || stg_gen != w.gen || prep_valid) r.st = ST_PERM;
          else begin
            stg_valid = 0; prep_valid = 1;
          end
        end
        ACT_PUBLISH: begin
          if (!prep_valid || stg_gen != w.gen) r.st = ST_PERM;
          else begin
            act_bank = stg_bank; act_valid = 1; act_gen = stg_gen; prep_valid = 0;
          end
        end
        ACT_ABORT: begin
          stg_valid = 0; prep_valid = 0;
        end
        ACT_RESET: begin
          stg_valid = 0; prep_valid = 0; act_valid = 0;
        end
        ACT_LOOKUP: begin
          if (act_valid && act_gen == cur_gen) begin
            for (int i = 0; i < 8; i++) begin
              var_w = (i == 3) ? 3'd4 : (i == 4) ? 3'd3 : 3'(i);
              if (probe(act_bank, w.ev, var_w[0] ? dom_any : w.subj,
                        var_w[1] ? dom_any : w.obj, var_w[2] ? sel_any : w.sel,
                        at) == 1) begin
                r.found = 1;
                r.dec = s_dec[at];
                break;
              end
            end
          end
        end
        default: r.st = ST_INVALID;
      endcase
      pending.push_back(r);
    endfunction

    function void check(logic [2:0] st, logic found, logic dec);
      verdict_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: status %0d found %0b", st, found);
        return;
      end
      e = pending.pop_front();
      if (st !== e.st || found !== e.found || dec !== e.dec) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status %0d/%0d found %0b/%0b decision %0b/%0b (exp/got)",
                   e.st, st, e.found, found, e.dec, dec);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_action = '0;
  logic [15:0] in_event_id = '0;
  logic [63:0] in_subject_domain = '0;
  logic [63:0] in_object_domain = '0;
  logic [63:0] in_selector = '0;
  logic [1:0]  in_rule_answer = '0;
  logic [63:0] in_generation = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [63:0] cfg_wdata = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_found;
  logic        out_decision;

  rule_scoreboard sb = new();
  int next_gap = 1;
  bit burst = 0;
  int stall_cnt = 0;

  wildcard_rule_hash_cache i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_status, out_found, out_decision);
    if ((start && !busy) || out_valid) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(word_t w);
    if (next_gap > 0) begin
      repeat (next_gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= w.action;
    in_event_id <= w.ev;
    in_subject_domain <= w.subj;
    in_object_domain <= w.obj;
    in_selector <= w.sel;
    in_rule_answer <= w.ans;
    in_generation <= w.gen;
    do @(posedge clk); while (busy);
    sb.note_input(w);
    next_gap = burst ? 0 : $urandom_range(0, 18);
    if (next_gap > 0) start <= 1'b0;
  endtask

  task automatic op(action_t a, logic [15:0] ev, logic [63:0] s, logic [63:0] o,
                    logic [63:0] p, logic [1:0] ans, logic [63:0] gen);
    word_t w;
    w.action = a; w.ev = ev; w.subj = s; w.obj = o; w.sel = p; w.ans = ans; w.gen = gen;
    send_word(w);
  endtask

  task automatic drain();
    @(posedge clk);
    start <= 1'b0;
    next_gap = 1;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [63:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_cfg(idx, val);
  endtask

  logic [63:0] ones = '1;

  initial begin
    logic [63:0] gen, dom, sany;
    logic [63:0] psub[4], pobj[4], psel[4];
    logic [15:0] pev[4];
    int nrules, nlook;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    op(ACT_LOOKUP, 16'h0, 0, 0, 0, 0, 0);
    op(ACT_RSVD, 16'hffff, ones, ones, ones, 3, ones);
    op(ACT_BEGIN, 0, 0, 0, 0, 0, 0);
    op(ACT_STAGE, 1, 2, 3, 4, 0, 0);
    op(ACT_PREPARE, 0, 0, 0, 0, 0, ones);
    op(ACT_PUBLISH, 0, 0, 0, 0, 0, ones);
    op(ACT_BEGIN, 0, 0, 0, 0, 0, ones);
    op(ACT_BEGIN, 0, 0, 0, 0, 0, 1);
    op(ACT_STAGE, 16'hffff, ones, ones, ones, 2, 0);
    op(ACT_STAGE, 16'hffff, ones, ones, ones, 3, 0);
    op(ACT_STAGE, 16'hffff, 0, 0, 0, 0, 0);
    op(ACT_STAGE, 16'h0, ones, ones, ones, 1, 0);
    op(ACT_STAGE, 16'hffff, 0, 0, 0, 1, 0);
    op(ACT_PREPARE, 0, 0, 0, 0, 0, 64'd1);
    op(ACT_PREPARE, 0, 0, 0, 0, 0, ones);
    op(ACT_PREPARE, 0, 0, 0, 0, 0, ones);
    op(ACT_STAGE, 5, 5, 5, 5, 0, 0);
    op(ACT_BEGIN, 0, 0, 0, 0, 0, 64'd9);
    op(ACT_PUBLISH, 0, 0, 0, 0, 0, 64'd2);
    op(ACT_PUBLISH, 0, 0, 0, 0, 0, ones);
    op(ACT_LOOKUP, 16'hffff, 0, 0, 0, 0, 0);
    write_cfg(CFG_CUR_GEN, ones);
    op(ACT_LOOKUP, 16'hffff, 0, 0, 0, 0, 0);
    op(ACT_LOOKUP, 16'h0, 64'd7, 64'd8, 64'd9, 0, 0);
    op(ACT_LOOKUP, 16'h0, ones, ones, ones, 0, 0);
    op(ACT_ABORT, 0, 0, 0, 0, 0, 0);
    op(ACT_RESET, 0, 0, 0, 0, 0, 0);
    op(ACT_LOOKUP, 16'h0, ones, ones, ones, 0, 0);

    // back-to-back burst of random rules
    write_cfg(CFG_CUR_GEN, 64'd7);
    op(ACT_BEGIN, 0, 0, 0, 0, 0, 64'd7);
    burst = 1;
    for (int i = 0; i < 40; i++)
      op(ACT_STAGE, 16'($urandom), rnd64(), rnd64(), rnd64(), 2'($urandom_range(0, 3)), 0);
    burst = 0;
    op(ACT_PREPARE, 0, 0, 0, 0, 0, 64'd7);
    op(ACT_PUBLISH, 0, 0, 0, 0, 0, 64'd7);
    op(ACT_LOOKUP, 16'($urandom), rnd64(), rnd64(), rnd64(), 0, 0);

    // random generations
    for (int rnd = 0; rnd < 20; rnd++) begin
      burst = ($urandom_range(0, 3) == 0);
      dom = (rnd == 0) ? 64'd0 : (rnd == 1) ? ones : ($urandom_range(0, 1) ? ones : rnd64());
      sany = (rnd == 0) ? 64'd0 : (rnd == 1) ? ones : ($urandom_range(0, 1) ? ones : rnd64());
      gen = (rnd == 2) ? ones : rnd64();
      if (gen == 0) gen = 1;
      write_cfg(CFG_DOMAIN_ANY, dom);
      write_cfg(CFG_SEL_ANY, sany);
      write_cfg(CFG_CUR_GEN, ($urandom_range(0, 4) == 0) ? rnd64() : gen);
      for (int i = 0; i < 4; i++) begin
        pev[i] = 16'($urandom);
        psub[i] = (i == 0) ? dom : rnd64();
        pobj[i] = (i == 1) ? dom : rnd64();
        psel[i] = (i == 2) ? sany : rnd64();
      end
      if ($urandom_range(0, 5) == 0) op(ACT_ABORT, 0, 0, 0, 0, 0, 0);
      op(ACT_BEGIN, 0, 0, 0, 0, 0, gen);
      nrules = $urandom_range(3, 14);
      for (int i = 0; i < nrules; i++)
        op(ACT_STAGE, pev[$urandom_range(0, 3)], psub[$urandom_range(0, 3)],
           pobj[$urandom_range(0, 3)], psel[$urandom_range(0, 3)],
           ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1)),
           rnd64());
      if ($urandom_range(0, 5) == 0) op(ACT_PREPARE, 0, 0, 0, 0, 0, rnd64());
      op(ACT_PREPARE, 0, 0, 0, 0, 0, gen);
      if ($urandom_range(0, 5) == 0) op(ACT_PUBLISH, 0, 0, 0, 0, 0, rnd64());
      op(ACT_PUBLISH, 0, 0, 0, 0, 0, gen);
      nlook = $urandom_range(8, 16);
      for (int i = 0; i < nlook; i++)
        op(ACT_LOOKUP, pev[$urandom_range(0, 3)], psub[$urandom_range(0, 3)],
           pobj[$urandom_range(0, 3)], psel[$urandom_range(0, 3)],
           2'($urandom), rnd64());
      for (int i = 0; i < 3; i++) begin
        action_t a;
        a = action_t'($urandom_range(0, 7));
        if (a == ACT_BEGIN && $urandom_range(0, 2) != 0) a = ACT_LOOKUP;
        op(a, 16'($urandom), rnd64(), rnd64(), rnd64(), 2'($urandom), rnd64());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
sv/wrhc_pkg.sv
sv/wrhc_ctrl.sv
sv/wrhc_dp.sv
sv/wildcard_rule_hash_cache.sv
sim/testbench.sv
